// ===== hw/rtl/itag_pkg.sv =====
// shared constants, configuration indexes and controller/datapath interface types
package itag_pkg;

  localparam int unsigned ADDRESS_BITS = 24;
  localparam int unsigned MaxTileDim   = 8;

  localparam int unsigned TileDimW  = $clog2(MaxTileDim + 1);
  localparam int unsigned TileCntW  = $clog2(MaxTileDim);
  localparam int unsigned BufIdxW   = $clog2(MaxTileDim * MaxTileDim);
  localparam int unsigned ImgWidthW = 13;
  localparam int unsigned TileNumW  = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned RowThW    = TileNumW + TileDimW;
  localparam int unsigned ColOffW   = ImgWidthW + TileDimW;
  localparam int unsigned ProdW     = RowThW + ImgWidthW;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TILE_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TILE_HEIGHT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TILE_COUNT  = 2'd3;

  localparam logic [ImgWidthW-1:0] RST_IMAGE_WIDTH = 13'd64;
  localparam logic [TileDimW-1:0]  RST_TILE_WIDTH  = 4'd8;
  localparam logic [TileDimW-1:0]  RST_TILE_HEIGHT = 4'd8;
  localparam logic [TileNumW-1:0]  RST_TILE_COUNT  = 16'd64;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel;
    logic mul;
    logic base;
    logic emit;
    logic err;
  } itag_cmd_t;

  typedef struct packed {
    logic range_err;
    logic div_busy;
    logic out_free;
    logic last;
  } itag_sts_t;

endpackage

// ===== hw/rtl/itag_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module itag_div import itag_pkg::*; #(
  parameter int unsigned DvdW = TileNumW,
  parameter int unsigned DsrW = ImgWidthW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic            busy_o,
  output logic [DvdW-1:0] quotient_o,
  output logic [DsrW-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DsrW-1:0] rem_q, rem_d;
  logic [DsrW-1:0] dsr_q, dsr_d;
  logic [DsrW:0]   shifted;
  logic            ge;

  assign shifted = {rem_q, quo_q[DvdW-1]};
  assign ge      = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DvdW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DvdW-2:0], ge};
      rem_d = ge ? DsrW'(shifted - {1'b0, dsr_q}) : shifted[DsrW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== hw/rtl/itag_datapath.sv =====
// configuration registers, tile position arithmetic, pixel walk and output register
module itag_datapath import itag_pkg::*; #(
  parameter int unsigned AddrBits = ADDRESS_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [TileNumW-1:0] tile_number_i,
  input  logic                out_stall_i,
  input  itag_cmd_t           cmd_i,
  output itag_sts_t           sts_o,
  output logic                out_valid_o,
  output logic [AddrBits-1:0] pixel_address_o,
  output logic [BufIdxW-1:0]  buffer_index_o,
  output logic                last_pixel_o,
  output logic                range_error_o
);

  logic [ImgWidthW-1:0] iw_q;
  logic [TileDimW-1:0]  tw_q, th_q;
  logic [TileNumW-1:0]  tc_q;
  logic [TileDimW-1:0]  tw_c, th_c;

  logic [TileNumW-1:0]  tn_q;
  logic [RowThW-1:0]    rowth_q;
  logic [ColOffW-1:0]   coloff_q;
  logic [ProdW-1:0]     prod_q;
  logic [AddrBits-1:0]  addr_q, row_start_q, row_next;
  logic [TileCntW-1:0]  row_q, col_q;
  logic [BufIdxW-1:0]   idx_q;
  logic                 last;

  logic                 out_valid_q;
  logic [AddrBits-1:0]  pix_q;
  logic [BufIdxW-1:0]   bidx_q;
  logic                 last_q, err_q;

  logic                 div_busy;
  logic [TileNumW-1:0]  div_quo;
  logic [ImgWidthW-1:0] div_rem;
  logic [TileNumW-1:0]  div_dvd;
  logic [ImgWidthW-1:0] div_dsr;

  assign tw_c = (tw_q > TileDimW'(MaxTileDim)) ? TileDimW'(MaxTileDim) : tw_q;
  assign th_c = (th_q > TileDimW'(MaxTileDim)) ? TileDimW'(MaxTileDim) : th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q <= RST_IMAGE_WIDTH;
      tw_q <= RST_TILE_WIDTH;
      th_q <= RST_TILE_HEIGHT;
      tc_q <= RST_TILE_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH: iw_q <= cfg_data_i[ImgWidthW-1:0];
        CFG_TILE_WIDTH:  tw_q <= cfg_data_i[TileDimW-1:0];
        CFG_TILE_HEIGHT: th_q <= cfg_data_i[TileDimW-1:0];
        CFG_TILE_COUNT:  tc_q <= cfg_data_i[TileNumW-1:0];
        default: ;
      endcase
    end
  end

  // first pass: tiles per row, second pass: tile row and column
  assign div_dvd = cmd_i.div_sel ? tn_q : TileNumW'(iw_q);
  assign div_dsr = cmd_i.div_sel ? div_quo[ImgWidthW-1:0] : ImgWidthW'(tw_c);

  itag_div #(
    .DvdW(TileNumW),
    .DsrW(ImgWidthW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  assign last = (TileDimW'(row_q) == th_c - TileDimW'(1))
             && (TileDimW'(col_q) == tw_c - TileDimW'(1));
  assign row_next = row_start_q + AddrBits'(iw_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tn_q <= tile_number_i;
    end
    if (cmd_i.mul) begin
      rowth_q  <= RowThW'(div_quo) * RowThW'(th_c);
      coloff_q <= ColOffW'(div_rem) * ColOffW'(tw_c);
    end
    if (cmd_i.base) begin
      prod_q <= ProdW'(rowth_q) * ProdW'(iw_q);
    end
  end

  // address start of the tile, then walk in raster order
  logic [ProdW-1:0] base_sum;
  logic             base_ld_q;
  assign base_sum = prod_q + ProdW'(coloff_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_ld_q <= 1'b0;
    end else begin
      base_ld_q <= cmd_i.base;
    end
  end

  always_ff @(posedge clk_i) begin
    if (base_ld_q) begin
      addr_q      <= base_sum[AddrBits-1:0];
      row_start_q <= base_sum[AddrBits-1:0];
      row_q       <= '0;
      col_q       <= '0;
      idx_q       <= '0;
    end else if (cmd_i.emit && !cmd_i.err) begin
      idx_q <= idx_q + BufIdxW'(1);
      if (TileDimW'(col_q) == tw_c - TileDimW'(1)) begin
        col_q       <= '0;
        row_q       <= row_q + TileCntW'(1);
        row_start_q <= row_next;
        addr_q      <= row_next;
      end else begin
        col_q  <= col_q + TileCntW'(1);
        addr_q <= addr_q + AddrBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cmd_i.err) begin
        pix_q  <= '0;
        bidx_q <= '0;
        last_q <= 1'b1;
        err_q  <= 1'b1;
      end else begin
        pix_q  <= addr_q;
        bidx_q <= idx_q;
        last_q <= last;
        err_q  <= 1'b0;
      end
    end
  end

  assign sts_o.range_err = (tn_q >= tc_q) || (tw_c == '0) || (th_c == '0)
                        || (iw_q < ImgWidthW'(tw_c));
  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.last      = last;

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = pix_q;
  assign buffer_index_o  = bidx_q;
  assign last_pixel_o    = last_q;
  assign range_error_o   = err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && err_q |-> last_q && (pix_q == '0) && (bidx_q == '0))
    else $error("error result with nonzero payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("result overwrites an unaccepted result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !cmd_i.err |-> (TileDimW'(row_q) < th_c) && (TileDimW'(col_q) < tw_c))
    else $error("pixel walk left the tile");

endmodule

// ===== hw/rtl/itag_ctrl.sv =====
// sequencing state machine for the tile request
module itag_ctrl import itag_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  itag_sts_t sts_i,
  output itag_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_PR    = 8'b0000_0100,
    S_TD    = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_BASE  = 8'b0010_0000,
    S_WALK  = 8'b0100_0000,
    S_ERR   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.range_err) begin
          state_d = S_ERR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_PR;
        end
      end
      S_PR: begin
        if (!sts_i.div_busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = S_TD;
        end
      end
      S_TD: begin
        if (!sts_i.div_busy) begin
          cmd_o.mul = 1'b1;
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.base = 1'b1;
        state_d    = S_BASE;
      end
      S_BASE: begin
        state_d = S_WALK;
      end
      S_WALK: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.err  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK && cmd_o.emit && sts_i.last |=> state_q == S_IDLE)
    else $error("walk did not end after last pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider restarted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && state_q == S_IDLE |=> state_q == S_CHECK)
    else $error("request not taken in idle");

endmodule

// ===== hw/rtl/image_tile_address_generator_core.sv =====
// top level of the raster tile address generator
//
// a request carries a tile number; the block answers with one result per
// pixel of that tile in raster order: linear image address, packed buffer
// index, a last flag on the final pixel. a tile number at or beyond the
// tile count, a zero tile size or an image narrower than one tile gives a
// single result with range_error and last_pixel set.
// both channels use valid/stall; a request is taken only while idle.
// after a request: a range check, two passes of the shared serial
// divider, then multiply and base add come before the first result, then
// one result per cycle while the output is not stalled, tile_width *
// tile_height results in all. an error result follows the check once
// the output is free. results sit in an output register, so the next
// request is taken while the last result still waits. a stall on the
// result side freezes the pixel walk. configuration registers are to be
// written only while idle; the user is bound by this, the block itself
// does not enforce it. reset clears the state machine and output valid
// and loads the register defaults: 64 wide image, 8x8 tiles, 64 tiles.
module image_tile_address_generator_core import itag_pkg::*; #(
  parameter int unsigned AddrBits = ADDRESS_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [TileNumW-1:0] tile_number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [AddrBits-1:0] pixel_address_o,
  output logic [BufIdxW-1:0]  buffer_index_o,
  output logic                last_pixel_o,
  output logic                range_error_o
);

  itag_cmd_t cmd;
  itag_sts_t sts;

  itag_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  itag_datapath #(
    .AddrBits(AddrBits)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .tile_number_i  (tile_number_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .pixel_address_o(pixel_address_o),
    .buffer_index_o (buffer_index_o),
    .last_pixel_o   (last_pixel_o),
    .range_error_o  (range_error_o)
  );

endmodule

// ===== test/image_tile_address_generator_core_tb.sv =====
`timescale 1ns / 1ps
// testbench for the raster tile address generator: directed and random tile requests checked per pixel
module image_tile_address_generator_core_tb;
  import itag_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxShown    = 20;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] addr;
    logic [BufIdxW-1:0]      idx;
    logic                    last;
    logic                    err;
  } pixel_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx = CFG_IMAGE_WIDTH;
  logic [CfgDataW-1:0]     cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [TileNumW-1:0]     tile_number = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ADDRESS_BITS-1:0] pixel_address;
  logic [BufIdxW-1:0]      buffer_index;
  logic                    last_pixel;
  logic                    range_error;

  logic [ImgWidthW-1:0] image_width_reg = RST_IMAGE_WIDTH;
  logic [TileDimW-1:0]  tile_width_reg  = RST_TILE_WIDTH;
  logic [TileDimW-1:0]  tile_height_reg = RST_TILE_HEIGHT;
  logic [TileNumW-1:0]  tile_count_reg  = RST_TILE_COUNT;

  pixel_result_t expected_pixels[$];
  pixel_result_t want;
  bit            idle_en = 1'b1;
  int unsigned   stall_left = 0;
  int unsigned   cycle_count = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   n_requests = 0;
  int unsigned   n_pixels = 0;
  int unsigned   n_range_errors = 0;
  int unsigned   n_configs = 0;

  image_tile_address_generator_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .tile_number_i   (tile_number),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .pixel_address_o (pixel_address),
    .buffer_index_o  (buffer_index),
    .last_pixel_o    (last_pixel),
    .range_error_o   (range_error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("image_tile_address_generator_core_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 3);
    end
    out_stall <= idle_en && (stall_left > 0);
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxShown) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // address walk of one tile request, in raster order inside the tile
  function automatic void predict_tile(input logic [TileNumW-1:0] tn);
    longint unsigned iw, tw, th, per_row, base, addr, r, c, tnl;
    pixel_result_t px;
    iw  = 64'(image_width_reg);
    tnl = 64'(tn);
    tw = (tile_width_reg > TileDimW'(MaxTileDim)) ? 64'(MaxTileDim) : 64'(tile_width_reg);
    th = (tile_height_reg > TileDimW'(MaxTileDim)) ? 64'(MaxTileDim) : 64'(tile_height_reg);
    per_row = (tw == 0) ? 0 : iw / tw;
    if (tn >= tile_count_reg || th == 0 || per_row == 0) begin
      px = '{addr: '0, idx: '0, last: 1'b1, err: 1'b1};
      expected_pixels.push_back(px);
      return;
    end
    base = (tnl % per_row) * tw + (tnl / per_row) * th * iw;
    for (r = 0; r < th; r++) begin
      for (c = 0; c < tw; c++) begin
        addr = base + r * iw + c;
        px.addr = addr[ADDRESS_BITS-1:0];
        px.idx  = BufIdxW'(r * tw + c);
        px.last = (r == th - 1) && (c == tw - 1);
        px.err  = 1'b0;
        expected_pixels.push_back(px);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0 && out_stall == 1'b0) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_address !== want.addr)
          report_mismatch($sformatf("pixel_address %0h, expected %0h", pixel_address, want.addr));
        if (buffer_index !== want.idx)
          report_mismatch($sformatf("buffer_index %0d, expected %0d", buffer_index, want.idx));
        if (last_pixel !== want.last)
          report_mismatch($sformatf("last_pixel %b, expected %b", last_pixel, want.last));
        if (range_error !== want.err)
          report_mismatch($sformatf("range_error %b, expected %b", range_error, want.err));
        if (want.err) n_range_errors++;
        else n_pixels++;
      end
    end
  end

  task automatic send_tile(input logic [TileNumW-1:0] tn);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    tile_number <= tn;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_tile(tn);
    n_requests++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [CfgDataW-1:0] iw, input logic [CfgDataW-1:0] tw,
                              input logic [CfgDataW-1:0] th, input logic [CfgDataW-1:0] tc);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, iw);
    write_reg(CFG_TILE_WIDTH, tw);
    write_reg(CFG_TILE_HEIGHT, th);
    write_reg(CFG_TILE_COUNT, tc);
    cfg_we <= 1'b0;
    image_width_reg = iw[ImgWidthW-1:0];
    tile_width_reg  = tw[TileDimW-1:0];
    tile_height_reg = th[TileDimW-1:0];
    tile_count_reg  = tc[TileNumW-1:0];
    n_configs++;
  endtask

  task automatic test_reset_defaults();
    send_tile(16'd0);
    send_tile(16'd63);
    send_tile(16'd64);
    send_tile(16'hFFFF);
  endtask

  task automatic test_geometry_extremes();
    // one tile per row on a 15 wide image gives the largest addresses
    apply_config(16'd15, 16'd8, 16'd8, 16'hFFFF);
    send_tile(16'hFFFF);
    send_tile(16'h5555);
    // oversized tile saturates on the widest image
    apply_config(16'd8191, 16'd15, 16'd15, 16'hFFFF);
    send_tile(16'hFFFF);
    send_tile(16'hAAAA);
    apply_config(16'd1, 16'd1, 16'd1, 16'hFFFF);
    send_tile(16'd0);
    send_tile(16'hFFFF);
    apply_config(16'd4096, 16'd1, 16'd8, 16'd2);
    send_tile(16'd1);
    send_tile(16'd2);
  endtask

  task automatic test_degenerate_geometry();
    apply_config(16'd0, 16'd8, 16'd8, 16'd64);
    send_tile(16'd0);
    apply_config(16'd7, 16'd8, 16'd8, 16'd64);
    send_tile(16'd0);
    apply_config(16'd64, 16'd0, 16'd8, 16'd64);
    send_tile(16'd0);
    apply_config(16'd64, 16'd8, 16'd0, 16'd64);
    send_tile(16'd0);
    apply_config(16'd64, 16'd8, 16'd8, 16'd0);
    send_tile(16'd0);
  endtask

  task automatic test_random_tiles(input int unsigned n_phases, input int unsigned per_phase);
    logic [CfgDataW-1:0] iw, tw, th, tc;
    logic [TileNumW-1:0] tn;
    int unsigned         pick, ph, k, n_items;
    for (ph = 0; ph < n_phases; ph++) begin
      idle_en = (ph != n_phases - 1) && (ph % 4 != 3);
      n_items = per_phase;
      tw = CfgDataW'($urandom_range(1, MaxTileDim));
      th = CfgDataW'($urandom_range(1, MaxTileDim));
      iw = CfgDataW'($urandom_range(8, 4096));
      pick = $urandom_range(0, 9);
      case (pick)
        0: iw = CfgDataW'($urandom_range(1, 2 * MaxTileDim));
        1: iw = $urandom_range(0, 1) ? 16'd4096 : 16'd8191;
        2: begin
          tw = CfgDataW'($urandom_range(MaxTileDim + 1, 15));
          th = CfgDataW'($urandom_range(MaxTileDim + 1, 15));
        end
        3: begin
          // geometry that leaves no tile to walk
          case ($urandom_range(0, 2))
            0: iw = 16'd0;
            1: tw = 16'd0;
            default: th = 16'd0;
          endcase
          n_items = per_phase / 5;
        end
        4: iw = CfgDataW'($urandom_range(4097, 8191));
        default: ;
      endcase
      case ($urandom_range(0, 2))
        0: tc = CfgDataW'($urandom_range(1, 64));
        1: tc = 16'hFFFF;
        default: tc = CfgDataW'($urandom_range(0, 16'hFFFF));
      endcase
      apply_config(iw, tw, th, tc);
      for (k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 49) == 0) wait_idle();
        pick = $urandom_range(0, 19);
        if (pick < 17 && tc != 0) tn = TileNumW'($urandom_range(0, tc - 1));
        else if (pick < 19 && tc != 16'hFFFF) tn = TileNumW'($urandom_range(tc, 16'hFFFF));
        else tn = TileNumW'($urandom);
        send_tile(tn);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_geometry_extremes();
    test_degenerate_geometry();
    test_random_tiles(10, 45);
    wait_idle();
    repeat (40) @(posedge clk);
    $display("%0d tile requests over %0d register settings", n_requests, n_configs);
    $display("%0d pixel results and %0d range errors checked, %0d mismatches",
             n_pixels, n_range_errors, mismatch_count);
    if (mismatch_count == 0) begin
      $display("image_tile_address_generator_core_tb: clean");
    end else begin
      $display("image_tile_address_generator_core_tb: errors");
    end
    $finish;
  end

endmodule
